>>> hdl/mmrd_pkg.sv
// Shared types, constants and helper functions for the MIDI message ring drain.
`default_nettype none

package mmrd_pkg;

    // Defaults for the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int BUDGET_MAX_DEF  = 63;

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int BUDGET_W = 6;
    localparam int LEN_W    = 2;

    // Item mode codes.
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Status byte codes.
    localparam logic [BYTE_W-1:0] STATUS_MIN      = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_SYSTEM   = 8'hF0;
    localparam logic [BYTE_W-1:0] STATUS_CLOCK    = 8'hF8;
    localparam logic [BYTE_W-1:0] STATUS_START    = 8'hFA;
    localparam logic [BYTE_W-1:0] STATUS_CONTINUE = 8'hFB;
    localparam logic [BYTE_W-1:0] STATUS_STOP     = 8'hFC;
    localparam logic [BYTE_W-1:0] STATUS_RESET    = 8'hFF;

    // Data bytes that follow the status byte, indexed by the upper nibble minus 8.
    localparam logic [LEN_W-1:0] DATA_LEN_TABLE [8] = '{
        2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0
    };

    // Input item.
    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] msg_status;
        logic [BYTE_W-1:0] msg_data_one;
        logic [BYTE_W-1:0] msg_data_two;
        logic [BUDGET_W-1:0] byte_budget;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                has_byte;
        logic [BUDGET_W-1:0] total_bytes;
        logic                last;
    } result_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        logic                is_drain;
        logic [BYTE_W-1:0]   status;
        logic [BYTE_W-1:0]   data_one;
        logic [BYTE_W-1:0]   data_two;
        logic [BUDGET_W-1:0] budget;
    } cmd_t;

    // One ring entry as stored in memory.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] data_one;
        logic [BYTE_W-1:0] data_two;
    } entry_t;

    // True when a status byte is forwarded rather than dropped.
    function automatic logic status_kept(input logic [BYTE_W-1:0] st);
        logic kept;
        begin
            if (st < STATUS_MIN) begin
                kept = 1'b0;
            end else if (st >= STATUS_SYSTEM) begin
                kept = (st == STATUS_CLOCK) || (st == STATUS_START) ||
                       (st == STATUS_CONTINUE) || (st == STATUS_STOP) ||
                       (st == STATUS_RESET);
            end else begin
                kept = 1'b1;
            end
            return kept;
        end
    endfunction

    // Number of data bytes for a kept status byte.
    function automatic logic [LEN_W-1:0] data_len(input logic [BYTE_W-1:0] st);
        return DATA_LEN_TABLE[st[6:4]];
    endfunction

endpackage

`default_nettype wire

>>> hdl/mmrd_front.sv
// Input side: accepts items, classifies them into commands and queues them.
`default_nettype none

module mmrd_front #(
    parameter int BUDGET_MAX = mmrd_pkg::BUDGET_MAX_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mmrd_pkg::item_t item,
    input  wire logic            push,
    output logic                 full,
    output mmrd_pkg::cmd_t       cmd,
    output logic                 cmd_valid,
    input  wire logic            cmd_pop
);

    mmrd_pkg::cmd_t cmd_in;
    mmrd_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_write, do_read;

    // Classify the item and clamp the drain budget.
    always_comb
    begin
        cmd_in.is_drain = (item.mode == mmrd_pkg::MODE_DRAIN);
        cmd_in.status   = item.msg_status;
        cmd_in.data_one = item.msg_data_one;
        cmd_in.data_two = item.msg_data_two;
        if (item.byte_budget > mmrd_pkg::BUDGET_W'(BUDGET_MAX)) begin
            cmd_in.budget = mmrd_pkg::BUDGET_W'(BUDGET_MAX);
        end else begin
            cmd_in.budget = item.byte_budget;
        end
    end

    // Two-entry command queue control.
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_write  = push && !full;
    assign do_read   = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_write ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read) begin
            count_next = count_reg + 2'd1;
        end else if (do_read && !do_write) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_write) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> hdl/mmrd_back.sv
// Execution side: holds the message ring, performs pushes and walks drains.
`default_nettype none

module mmrd_back #(
    parameter int QUEUE_DEPTH = mmrd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mmrd_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    output mmrd_pkg::result_t   res,
    output logic                res_push,
    input  wire logic           res_full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Ring storage with a registered read port.
    mmrd_pkg::entry_t mem [QUEUE_DEPTH];
    mmrd_pkg::entry_t rdata_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    mmrd_pkg::entry_t mem_wdata;

    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] clr_reg, clr_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [mmrd_pkg::BUDGET_W-1:0] budget_reg, budget_next;
    logic [mmrd_pkg::BUDGET_W-1:0] n_reg, n_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [mmrd_pkg::BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    mmrd_pkg::entry_t msg_reg, msg_next;
    logic [mmrd_pkg::LEN_W-1:0] len_reg, len_next;
    logic [mmrd_pkg::LEN_W-1:0] idx_reg, idx_next;

    logic                        eval_kept;
    logic [mmrd_pkg::LEN_W-1:0]  eval_len;
    logic                        eval_fits;
    logic [mmrd_pkg::BYTE_W-1:0] cur_byte;

    // Next pointer around the ring.
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
    endfunction

    // Classification of the entry just read.
    always_comb
    begin
        eval_kept = mmrd_pkg::status_kept(rdata_reg.status);
        eval_len  = mmrd_pkg::data_len(rdata_reg.status) + mmrd_pkg::LEN_W'(1);
        eval_fits = ({1'b0, n_reg} + (mmrd_pkg::BUDGET_W + 1)'(eval_len))
                    <= {1'b0, budget_reg};
    end

    // Byte of the current message being serialized.
    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = msg_reg.status;
            2'd1:    cur_byte = msg_reg.data_one;
            default: cur_byte = msg_reg.data_two;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        budget_next     = budget_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        msg_next        = msg_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = wp_reg;
        mem_wdata       = '0;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Invalidate one entry per cycle after reset.
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == PTR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_drain) begin
                        mem_we             = 1'b1;
                        mem_waddr          = wp_reg;
                        mem_wdata.valid    = 1'b1;
                        mem_wdata.status   = cmd.status;
                        mem_wdata.data_one = cmd.data_one;
                        mem_wdata.data_two = cmd.data_two;
                        wp_next            = advance(wp_reg);
                    end else begin
                        budget_next     = cmd.budget;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!rdata_reg.valid || (eval_kept && !eval_fits)) begin
                    state_next = ST_FINISH;
                end else begin
                    // Consume the entry.
                    mem_we    = 1'b1;
                    mem_waddr = rp_reg;
                    rp_next   = advance(rp_reg);
                    if (eval_kept) begin
                        msg_next   = rdata_reg;
                        len_next   = eval_len;
                        idx_next   = '0;
                        n_next     = n_reg + mmrd_pkg::BUDGET_W'(eval_len);
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                // The held byte goes out once a newer one exists.
                if (!(pend_valid_reg && res_full)) begin
                    if (pend_valid_reg) begin
                        res_push       = 1'b1;
                        res.out_byte   = pend_byte_reg;
                        res.has_byte   = 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pend_byte_next  = cur_byte;
                    if (idx_reg == len_reg - mmrd_pkg::LEN_W'(1)) begin
                        state_next = ST_READ;
                    end else begin
                        idx_next = idx_reg + mmrd_pkg::LEN_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                // Final result carries the total, or marks an empty drain.
                if (!res_full) begin
                    res_push        = 1'b1;
                    res.last        = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg) begin
                        res.out_byte    = pend_byte_reg;
                        res.has_byte    = 1'b1;
                        res.total_bytes = n_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Working registers of a drain.
    always_ff @(posedge clk)
    begin
        budget_reg    <= budget_next;
        n_reg         <= n_next;
        pend_byte_reg <= pend_byte_next;
        msg_reg       <= msg_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rp_reg];
    end

endmodule

`default_nettype wire

>>> hdl/mmrd_outq.sv
// Result queue that separates the drain engine from the consumer.
`default_nettype none

module mmrd_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mmrd_pkg::result_t res,
    input  wire logic              res_push,
    output logic                   res_full,
    output mmrd_pkg::result_t      result,
    output logic                   empty,
    input  wire logic              pop
);

    mmrd_pkg::result_t slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_write, do_read;

    // Two-entry queue control.
    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign result   = slot_reg[rd_ptr_reg];
    assign do_write = res_push && !res_full;
    assign do_read  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_write ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read) begin
            count_next = count_reg + 2'd1;
        end else if (do_read && !do_write) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_write) begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire

>>> hdl/midi_message_ring_drain.sv
// Top level of the MIDI message ring with budgeted byte-serial drain.
//
//  Channel  Handshake       Payload               Direction
//  input    push / full     item   (item_t)       in
//  result   pop / empty     result (result_t)     out
//
// A push waits in the input queue until the engine is idle, which then
// writes it into the ring. A drain reads each ring entry it visits, the
// entry that stops it included, through the engine's single registered
// read port, and serializes the bytes of every kept message in order.
// After reset the engine invalidates every ring entry, one entry per cycle;
// items are queued meanwhile until the input queue fills.
// Two-entry queues on the input and result sides let either side stall alone.
`default_nettype none

module midi_message_ring_drain #(
    parameter int QUEUE_DEPTH = mmrd_pkg::QUEUE_DEPTH_DEF,
    parameter int BUDGET_MAX  = mmrd_pkg::BUDGET_MAX_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mmrd_pkg::item_t   item,
    input  wire logic              push,
    output logic                   full,
    output mmrd_pkg::result_t      result,
    output logic                   empty,
    input  wire logic              pop
);

    mmrd_pkg::cmd_t    cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    mmrd_pkg::result_t res;
    logic              res_push;
    logic              res_full;

    // Input side.
    mmrd_front #(
        .BUDGET_MAX (BUDGET_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Ring and drain engine.
    mmrd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result side.
    mmrd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_push (res_push),
        .res_full (res_full),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

    // An item without a byte is only ever the closing item of an empty drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.has_byte) |-> (result.last && result.total_bytes == '0))
    else $error("empty-drain item is malformed");

    // The byte total appears only on the closing item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.last) |-> (result.total_bytes == '0))
    else $error("byte total on a non-closing item");

    // A closing item that carries a byte reports a nonzero total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last && result.has_byte) |-> (result.total_bytes != '0))
    else $error("closing item with byte has zero total");

    // The engine never hands the result queue an item it cannot take.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
    else $error("result pushed while result queue is full");

endmodule

`default_nettype wire

>>> tb/tb_midi_message_ring_drain.sv
// Self-checking testbench for the MIDI message ring drain: directed table and random traffic.
module tb_midi_message_ring_drain;

    localparam int RING_SIZE   = mmrd_pkg::QUEUE_DEPTH_DEF;
    localparam int BUDGET_CAP  = mmrd_pkg::BUDGET_MAX_DEF;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 10;
    localparam longint LIMIT   = 64'd5_000_000;

    // A drain that emits nothing answers with this single result.
    localparam mmrd_pkg::result_t NO_BYTES = '{out_byte: 8'h00, has_byte: 1'b0,
                                               total_bytes: 6'd0, last: 1'b1};

    typedef struct {
        mmrd_pkg::item_t   it;
        bit                typed;
        mmrd_pkg::result_t exp;
    } row_t;

    logic              clk;
    logic              rst_n;
    mmrd_pkg::item_t   item;
    logic              push;
    logic              full;
    mmrd_pkg::result_t result;
    logic              empty;
    logic              pop;

    // Shadow copy of the ring and its pointers.
    logic [23:0] slot_msg [RING_SIZE];
    bit          slot_live [RING_SIZE];
    int          wr_idx = 0;
    int          rd_idx = 0;

    // Serialized bytes still owed by the block, oldest first.
    mmrd_pkg::result_t due [$];

    int  mismatches = 0;
    int  n_push = 0;
    int  n_drain = 0;
    int  n_empty_drain = 0;
    int  n_results = 0;
    int  n_full_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;

    midi_message_ring_drain #(
        .QUEUE_DEPTH(RING_SIZE),
        .BUDGET_MAX (BUDGET_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .push  (push),
        .full  (full),
        .result(result),
        .empty (empty),
        .pop   (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT);
        $display("Timeout with %0d results still owed.", due.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic mmrd_pkg::item_t make_item(input logic m, input logic [7:0] st,
                                                  input logic [7:0] d1, input logic [7:0] d2,
                                                  input logic [5:0] bud);
        mmrd_pkg::item_t it;
        it.mode         = m;
        it.msg_status   = st;
        it.msg_data_one = d1;
        it.msg_data_two = d2;
        it.byte_budget  = bud;
        return it;
    endfunction

    // A push item; the budget field is left at zero.
    function automatic mmrd_pkg::item_t push_item(input logic [7:0] st,
                                                  input logic [7:0] d1, input logic [7:0] d2);
        return make_item(mmrd_pkg::MODE_PUSH, st, d1, d2, 6'd0);
    endfunction

    // A drain item; the message fields are left at zero.
    function automatic mmrd_pkg::item_t drain_item(input logic [5:0] bud);
        return make_item(mmrd_pkg::MODE_DRAIN, 8'h00, 8'h00, 8'h00, bud);
    endfunction

    // Channel messages pass, system bytes pass only for the real-time set.
    function automatic bit msg_forwarded(input logic [7:0] st);
        if (st < mmrd_pkg::STATUS_MIN)
            return 1'b0;
        if (st < mmrd_pkg::STATUS_SYSTEM)
            return 1'b1;
        return (st == mmrd_pkg::STATUS_CLOCK) || (st == mmrd_pkg::STATUS_START) ||
               (st == mmrd_pkg::STATUS_CONTINUE) || (st == mmrd_pkg::STATUS_STOP) ||
               (st == mmrd_pkg::STATUS_RESET);
    endfunction

    // Bytes on the wire, status included.
    function automatic int msg_len(input logic [7:0] st);
        case (st[7:4])
            4'hC, 4'hD: return 2;
            4'hF:       return 1;
            default:    return 3;
        endcase
    endfunction

    // Apply one item to the shadow ring and queue the results it causes.
    function automatic void serialize(input mmrd_pkg::item_t it);
        logic [7:0]        st;
        logic [7:0]        wire_bytes [$];
        mmrd_pkg::result_t r;
        int                cap;
        int                len;
        int                steps;
        if (it.mode == mmrd_pkg::MODE_PUSH)
        begin
            slot_msg[wr_idx]  = {it.msg_status, it.msg_data_one, it.msg_data_two};
            slot_live[wr_idx] = 1'b1;
            if (wr_idx == RING_SIZE - 1)
                wr_idx = 0;
            else
                wr_idx++;
            n_push++;
            return;
        end

        n_drain++;
        cap = int'(it.byte_budget);
        if (cap > BUDGET_CAP)
            cap = BUDGET_CAP;

        // Walk live entries; a message that does not fit stays where it is.
        for (steps = 0; steps < RING_SIZE && slot_live[rd_idx]; steps++)
        begin
            st = slot_msg[rd_idx][23:16];
            if (msg_forwarded(st))
            begin
                len = msg_len(st);
                if (wire_bytes.size() + len > cap)
                    break;
                wire_bytes.push_back(st);
                if (len >= 2)
                    wire_bytes.push_back(slot_msg[rd_idx][15:8]);
                if (len == 3)
                    wire_bytes.push_back(slot_msg[rd_idx][7:0]);
            end
            slot_live[rd_idx] = 1'b0;
            if (rd_idx == RING_SIZE - 1)
                rd_idx = 0;
            else
                rd_idx++;
        end

        if (wire_bytes.size() == 0)
        begin
            due.push_back(NO_BYTES);
            n_empty_drain++;
            return;
        end
        foreach (wire_bytes[k])
        begin
            r.out_byte    = wire_bytes[k];
            r.has_byte    = 1'b1;
            r.last        = (k == wire_bytes.size() - 1);
            r.total_bytes = r.last ? 6'(wire_bytes.size()) : 6'd0;
            due.push_back(r);
        end
    endfunction

    function automatic logic [7:0] kept_status();
        if ($urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return mmrd_pkg::STATUS_CLOCK;
                1:       return mmrd_pkg::STATUS_START;
                2:       return mmrd_pkg::STATUS_CONTINUE;
                3:       return mmrd_pkg::STATUS_STOP;
                default: return mmrd_pkg::STATUS_RESET;
            endcase
        end
        return {4'($urandom_range(8, 14)), 4'($urandom)};
    endfunction

    // Data bytes as status, or system bytes outside the real-time set.
    function automatic logic [7:0] dropped_status();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 127));
        case ($urandom_range(0, 3))
            0:       return mmrd_pkg::STATUS_SYSTEM + 8'($urandom_range(0, 7));
            1:       return mmrd_pkg::STATUS_CLOCK + 8'd1;
            2:       return mmrd_pkg::STATUS_STOP + 8'd1;
            default: return mmrd_pkg::STATUS_STOP + 8'd2;
        endcase
    endfunction

    // Directed table; the expected result is typed in only for the obvious rows.
    function automatic row_t dir_row(input int idx);
        row_t r;
        r.typed = 1'b0;
        r.exp   = NO_BYTES;
        case (idx)
            0:
            begin
                // Drain of a ring that has never been written.
                r.it = make_item(mmrd_pkg::MODE_DRAIN, 8'hFF, 8'hFF, 8'hFF, 6'd63);
                r.typed = 1'b1;
            end
            // Messages that are dropped, then a zero budget that still consumes them.
            1: r.it = push_item(8'h00, 8'h00, 8'h00);
            2: r.it = make_item(mmrd_pkg::MODE_PUSH, 8'h7F, 8'hFF, 8'hFF, 6'd63);
            3: r.it = push_item(mmrd_pkg::STATUS_SYSTEM, 8'h11, 8'h22);
            4: r.it = push_item(mmrd_pkg::STATUS_RESET - 8'd1, 8'h33, 8'h44);
            5:
            begin
                r.it    = drain_item(6'd0);
                r.typed = 1'b1;
            end
            // One message of every length class and every kept system byte.
            6: r.it = push_item(mmrd_pkg::STATUS_MIN, 8'h00, 8'h7F);
            7: r.it = push_item(8'h9F, 8'hFF, 8'hFF);
            8: r.it = push_item(8'hC0, 8'h12, 8'h34);
            9: r.it = push_item(8'hDF, 8'h55, 8'hAA);
            10: r.it = push_item(8'hEF, 8'h00, 8'hFF);
            11: r.it = push_item(mmrd_pkg::STATUS_CLOCK, 8'h01, 8'h02);
            12: r.it = push_item(mmrd_pkg::STATUS_START, 8'h03, 8'h04);
            13: r.it = push_item(mmrd_pkg::STATUS_CONTINUE, 8'h05, 8'h06);
            14: r.it = push_item(mmrd_pkg::STATUS_STOP, 8'h07, 8'h08);
            15: r.it = push_item(mmrd_pkg::STATUS_RESET, 8'h09, 8'h0A);
            16:
            begin
                // Budget too small for the first message: nothing moves.
                r.it    = drain_item(6'd2);
                r.typed = 1'b1;
            end
            // Exact fit, then the rest in one drain.
            17: r.it = make_item(mmrd_pkg::MODE_DRAIN, 8'hFF, 8'hFF, 8'hFF, 6'd3);
            18: r.it = drain_item(6'd63);
            // A lone clock byte: data bytes are not sent.
            19: r.it = push_item(mmrd_pkg::STATUS_CLOCK, 8'h12, 8'h34);
            20:
            begin
                r.it    = drain_item(6'd63);
                r.typed = 1'b1;
                r.exp   = '{out_byte: mmrd_pkg::STATUS_CLOCK, has_byte: 1'b1,
                            total_bytes: 6'd1, last: 1'b1};
            end
            21: r.it = push_item(8'hB3, 8'hA5, 8'h5A);
            22: r.it = push_item(mmrd_pkg::STATUS_CLOCK + 8'd1, 8'h00, 8'h00);
            23: r.it = drain_item(6'd63);
            default:
            begin
                r.it    = drain_item(6'd1);
                r.typed = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then record what it owes.
    task automatic offer(input mmrd_pkg::item_t it, input bit typed,
                         input mmrd_pkg::result_t exp);
        int base;
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        do
        begin
            @(posedge clk);
            if (full)
                n_full_cycles++;
        end
        while (full);
        base = due.size();
        serialize(it);
        if (typed)
        begin
            while (due.size() > base)
                void'(due.pop_back());
            due.push_back(exp);
        end
    endtask

    // Compare one taken result with the oldest owed byte.
    task automatic take_result(input mmrd_pkg::result_t got);
        mmrd_pkg::result_t want;
        n_results++;
        if (due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Result %0d arrived with nothing owed: %s",
                         n_results,
                         $sformatf("byte=%02h has=%0b total=%0d last=%0b",
                                   got.out_byte, got.has_byte, got.total_bytes,
                                   got.last));
            return;
        end
        want = due.pop_front();
        if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
            got.total_bytes !== want.total_bytes || got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("Result %0d: expected byte=%02h has=%0b total=%0d last=%0b,",
                         n_results, want.out_byte, want.has_byte, want.total_bytes,
                         want.last);
                $display("    got byte=%02h has=%0b total=%0d last=%0b",
                         got.out_byte, got.has_byte, got.total_bytes, got.last);
            end
        end
    endtask

    // Result side: random pop, one long hold-off while the sender keeps going.
    initial
    begin : result_sink
        int held;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                take_result(result);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            pop <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        row_t       row;
        int         sent;
        int         burst;
        int         k;
        logic [7:0] st;
        logic [5:0] bud;

        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (k = 0; k < DIR_ROWS; k++)
        begin
            row = dir_row(k);
            offer(row.it, row.typed, row.exp);
        end

        // Random traffic: mostly bursts of messages followed by a drain.
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            steady = (sent >= 45 && sent < 80);
            if (sent >= 20)
                hold_go = 1'b1;
            if ($urandom_range(0, 99) < 75)
            begin
                burst = $urandom_range(1, 6);
                for (k = 0; k < burst; k++)
                begin
                    st = ($urandom_range(0, 7) == 0) ? dropped_status() : kept_status();
                    offer(make_item(mmrd_pkg::MODE_PUSH, st, 8'($urandom), 8'($urandom),
                                    6'($urandom)),
                          1'b0, NO_BYTES);
                end
                bud = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 6))
                                                  : 6'($urandom_range(7, 63));
                offer(make_item(mmrd_pkg::MODE_DRAIN, 8'($urandom), 8'($urandom),
                                8'($urandom), bud),
                      1'b0, NO_BYTES);
                sent += burst + 1;
            end
            else
            begin
                offer(make_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                6'($urandom)), 1'b0, NO_BYTES);
                sent++;
            end
        end
        steady = 1'b0;

        // Empty the ring, then check that a further drain finds nothing.
        while (slot_live[rd_idx])
            offer(make_item(mmrd_pkg::MODE_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom),
                            6'($urandom_range(24, 63))), 1'b0, NO_BYTES);
        offer(drain_item(6'd63), 1'b1, NO_BYTES);
        push <= 1'b0;

        // Let every owed byte come out, then watch for strays.
        while (due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d pushes and %0d drains (%0d with no bytes); %0d results checked.",
                 n_push, n_drain, n_empty_drain, n_results);
        $display("Input held full for %0d offered cycles; result side paused %0d cycles once.",
                 n_full_cycles, HOLD_CYCLES);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> midi_message_ring_drain.f
hdl/mmrd_pkg.sv
hdl/mmrd_front.sv
hdl/mmrd_back.sv
hdl/mmrd_outq.sv
hdl/midi_message_ring_drain.sv
tb/tb_midi_message_ring_drain.sv
